// ----- design/assert_macros.svh -----
// Assertion macros for the RTL file that carries concurrent checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent in one cycle implies a consequent in the next cycle.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// No dependencies; imported by every module of the block but deq_ram.
package deq_pkg;

    localparam int FIELD_W = 32;
    localparam int CMD_W   = 3;
    localparam int ERR_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_NOP        = 3'd4
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the request fields
        logic exec;   // apply the operation and write the store
        logic read;   // read the front and back entries
    } deq_ctl_t;

endpackage

// ----- design/deq_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- design/deq_ctrl.sv -----
// Controller of the double-ended queue: sequences accept, execute, read and respond.
// Depends on deq_pkg.
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output deq_pkg::deq_ctl_t ctl
);

    import deq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    // A new request may enter while the previous response is shown.
    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg) inside
                ST_IDLE, ST_RESP:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= ST_EXEC;
                        busy_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_RESP;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign ctl.load = accept;
    assign ctl.exec = (state_reg == ST_EXEC);
    assign ctl.read = (state_reg == ST_READ);

endmodule

// ----- design/deq_dpath.sv -----
// Datapath of the double-ended queue: indices, fill count, error code and entry store.
// Depends on deq_pkg and deq_ram.
module deq_dpath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  deq_pkg::deq_ctl_t            ctl,
    input  logic [deq_pkg::CMD_W-1:0]    cmd,
    input  logic [deq_pkg::FIELD_W-1:0]  item_value,
    output logic [deq_pkg::FIELD_W-1:0]  front_value,
    output logic [deq_pkg::FIELD_W-1:0]  back_value,
    output logic [CNT_W-1:0]             entry_total,
    output logic                         is_empty,
    output logic [deq_pkg::ERR_W-1:0]    error_code
);

    import deq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int EXT_W = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

    cmd_t                 cmd_reg;
    logic [FIELD_W-1:0]   value_reg;
    logic [IDX_W-1:0]     front_reg, front_next;
    logic [IDX_W-1:0]     back_reg, back_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    err_t                 err_reg, err_next;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [EXT_W-1:0]     wdata_ext;
    logic [DATA_WIDTH-1:0] front_rdata;
    logic [DATA_WIDTH-1:0] back_rdata;
    logic [EXT_W-1:0]     front_ext;
    logic [EXT_W-1:0]     back_ext;
    logic [IDX_W-1:0]     front_prev;
    logic [IDX_W-1:0]     back_succ;
    logic                 full;
    logic                 empty;

    // Request fields are payload and carry no reset.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd_t'(cmd);
            value_reg <= item_value;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign front_prev = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign back_succ  = (back_reg == IDX_W'(DEPTH - 1)) ? '0 : back_reg + 1'b1;

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        err_next   = err_reg;
        we         = 1'b0;
        waddr      = front_reg;
        if (ctl.exec)
        begin
            err_next = ERR_OK;
            unique case (cmd_reg) inside
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (empty)
                        begin
                            back_next = front_reg;
                            waddr     = front_reg;
                        end
                        else if (cmd_reg == CMD_PUSH_FRONT)
                        begin
                            front_next = front_prev;
                            waddr      = front_prev;
                        end
                        else
                        begin
                            back_next = back_succ;
                            waddr     = back_succ;
                        end
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        err_next = ERR_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        // Popping the last entry leaves both indices where they are.
                        if (count_reg > CNT_W'(1))
                        begin
                            if (cmd_reg == CMD_POP_FRONT)
                            begin
                                front_next = (front_reg == IDX_W'(DEPTH - 1)) ?
                                             '0 : front_reg + 1'b1;
                            end
                            else
                            begin
                                back_next = (back_reg == '0) ?
                                            IDX_W'(DEPTH - 1) : back_reg - 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
            err_reg   <= ERR_OK;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    assign wdata_ext = EXT_W'(value_reg);

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata_ext[DATA_WIDTH-1:0]),
        .re      (ctl.read),
        .raddr_a (front_reg),
        .raddr_b (back_reg),
        .rdata_a (front_rdata),
        .rdata_b (back_rdata)
    );

    assign front_ext   = EXT_W'(front_rdata);
    assign back_ext    = EXT_W'(back_rdata);
    assign front_value = empty ? '0 : front_ext[FIELD_W-1:0];
    assign back_value  = empty ? '0 : back_ext[FIELD_W-1:0];
    assign entry_total = count_reg;
    assign is_empty    = empty;
    assign error_code  = err_reg;

endmodule

// ----- design/double_ended_queue.sv -----
// Top level of the bounded double-ended queue: controller plus datapath.
// Depends on deq_pkg, deq_ctrl, deq_dpath, deq_ram and assert_macros.svh.
//
//  Channel    Handshake           Fields
//  ---------  ------------------  ------------------------------------------------
//  request    start, busy         cmd, item_value
//  response   done (one cycle)    front_value, back_value, entry_total,
//                                 is_empty, error_code
//
// A request is taken at a rising edge where start is high and busy is low.
// It runs through execute and write of the store, a registered read of both
// ends, and a response with done high. busy is low in the response cycle, so
// the next request can be taken while the previous response is shown.
// rst_n clears indices, count, error code and controller; the store has no reset.
// The receiver cannot stall: the response is valid only while done is high.
`include "assert_macros.svh"

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [deq_pkg::CMD_W-1:0]    cmd,
    input  logic [deq_pkg::FIELD_W-1:0]  item_value,
    output logic                         done,
    output logic [deq_pkg::FIELD_W-1:0]  front_value,
    output logic [deq_pkg::FIELD_W-1:0]  back_value,
    output logic [CNT_W-1:0]             entry_total,
    output logic                         is_empty,
    output logic [deq_pkg::ERR_W-1:0]    error_code
);

    import deq_pkg::*;

    deq_ctl_t ctl;

    // The controller only sequences the steps; all state of the queue
    // itself lives in the datapath.
    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    deq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmd         (cmd),
        .item_value  (item_value),
        .front_value (front_value),
        .back_value  (back_value),
        .entry_total (entry_total),
        .is_empty    (is_empty),
        .error_code  (error_code)
    );

    // The count never exceeds the capacity of the store.
    `DEQ_ASSERT(a_count_bound, clk, rst_n, entry_total <= CNT_W'(DEPTH), "count above depth")

    // A full-store rejection is only reported while the store is full.
    `DEQ_ASSERT(a_full_err, clk, rst_n,
        !(done && (error_code == ERR_FULL)) || (entry_total == CNT_W'(DEPTH)),
        "full error with room left")

    // An empty store reports zero for both end values.
    `DEQ_ASSERT(a_empty_zero, clk, rst_n,
        !is_empty || ((front_value == '0) && (back_value == '0)),
        "nonzero end value on empty store")

    // The response strobe lasts exactly one cycle.
    `DEQ_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done held over two cycles")

    // An accepted request always makes the block busy in the next cycle.
    `DEQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done,
        "accepted request did not start work")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the double_ended_queue block.
// Depends on deq_pkg and the RTL of double_ended_queue; needs no other file.
// A clocked driver sends requests from a backlog, and a clocked monitor checks every response.
module testbench;

    import deq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int TOTAL_W     = $clog2(DEPTH + 1);
    localparam int RESET_CYCLES = 10;
    // Stop after this many cycles in which no request and no response moves.
    localparam int QUIET_LIMIT = 1000;
    // Cycles to wait at the end, after the last response has been checked.
    localparam int TAIL_CYCLES = 8;
    // Count of random requests that change or probe the queue. No-ops do not count.
    localparam int RANDOM_OPS  = 1450;
    localparam int CMD_WIDTH   = CMD_W;

    // The command field is three bits wide. Codes above CMD_NOP should act as no-ops.
    localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]   code;
        logic [FIELD_W-1:0] value;
        bit                 drain_first;   // hold this request until every response is back
    } deq_request_t;

    typedef struct {
        logic [FIELD_W-1:0] front;
        logic [FIELD_W-1:0] back;
        logic [TOTAL_W-1:0] total;
        logic               empty;
        logic [ERR_W-1:0]   err;
    } deq_response_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               start      = 1'b0;
    logic [CMD_W-1:0]   cmd        = CMD_NOP;
    logic [FIELD_W-1:0] item_value = '0;
    logic               busy;
    logic               done;
    logic [FIELD_W-1:0] front_value;
    logic [FIELD_W-1:0] back_value;
    logic [TOTAL_W-1:0] entry_total;
    logic               is_empty;
    logic [ERR_W-1:0]   error_code;

    double_ended_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .item_value  (item_value),
        .done        (done),
        .front_value (front_value),
        .back_value  (back_value),
        .entry_total (entry_total),
        .is_empty    (is_empty),
        .error_code  (error_code)
    );

    always #1 clk = ~clk;

    // The stimulus backlog is filled at time zero. The driver empties it.
    deq_request_t  request_backlog[$];
    // Predicted responses, oldest first. The block answers requests in order.
    deq_response_t pending_responses[$];
    int            error_count = 0;

    // This is the testbench's own copy of the queue state. The 4-bit slot indices wrap
    // around the 16-entry ring without explicit modulo arithmetic.
    logic [FIELD_W-1:0] shadow_slots[DEPTH];
    logic [3:0]         shadow_head  = '0;
    logic [3:0]         shadow_tail  = '0;
    int                 shadow_fill  = 0;

    // Apply one request to the shadow queue and return the response the block should give.
    function automatic deq_response_t predict_response(logic [CMD_W-1:0] code,
                                                       logic [FIELD_W-1:0] value);
        deq_response_t rsp;
        bit            at_front;
        rsp.err  = ERR_OK;
        at_front = (code == CMD_PUSH_FRONT) || (code == CMD_POP_FRONT);
        case (code)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (shadow_fill == DEPTH)
                    rsp.err = ERR_FULL;
                else
                begin
                    // In an empty queue, the first entry goes at the head slot,
                    // and both ends point at that slot.
                    if (shadow_fill == 0)
                        shadow_tail = shadow_head;
                    else if (at_front)
                        shadow_head = shadow_head - 4'd1;
                    else
                        shadow_tail = shadow_tail + 4'd1;
                    shadow_slots[at_front ? shadow_head : shadow_tail] = value;
                    shadow_fill++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (shadow_fill == 0)
                    rsp.err = ERR_EMPTY;
                else
                begin
                    // When the last entry is popped, both indices stay where they are.
                    if (shadow_fill > 1)
                    begin
                        if (at_front)
                            shadow_head = shadow_head + 4'd1;
                        else
                            shadow_tail = shadow_tail - 4'd1;
                    end
                    shadow_fill--;
                end
            end
            default:
                ;
        endcase
        // An empty queue shows zero at both ends.
        rsp.front = (shadow_fill == 0) ? '0 : shadow_slots[shadow_head];
        rsp.back  = (shadow_fill == 0) ? '0 : shadow_slots[shadow_tail];
        rsp.total = TOTAL_W'(shadow_fill);
        rsp.empty = (shadow_fill == 0);
        return rsp;
    endfunction

    function automatic void add_request(logic [CMD_W-1:0] code, logic [FIELD_W-1:0] value,
                                        bit drain_first);
        deq_request_t req;
        req.code        = code;
        req.value       = value;
        req.drain_first = drain_first;
        request_backlog.insert(request_backlog.size(), req);
    endfunction

    // Return a push value. All-zero and all-one values come up often, so the
    // front and back outputs see both extremes.
    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Driver. A request is taken at an edge where start is high and busy is low.
    // The driver predicts the response at that edge. start stays high until the
    // request is taken. After that, the driver either presents the next request
    // or opens a gap. The next value of start is worked out first and assigned
    // once, so start never gets two updates in one time step.
    int burst_left = 1;
    int idle_left  = 0;

    always @(posedge clk)
    begin : drive_requests
        bit           accepted;
        bit           next_start;
        deq_request_t req;
        accepted   = start && !busy;
        next_start = 1'b0;
        if (accepted)
            pending_responses.insert(pending_responses.size(),
                                     predict_response(cmd, item_value));
        if (!rst_n)
            next_start = 1'b0;
        else if (start && !accepted)
            next_start = 1'b1;
        else if (idle_left > 0)
            idle_left--;
        else if (request_backlog.size() > 0 &&
                 (!request_backlog[0].drain_first ||
                  (pending_responses.size() == 0 && !accepted)))
        begin
            req = request_backlog[0];
            request_backlog.delete(0);
            cmd        <= req.code;
            item_value <= req.value;
            next_start = 1'b1;
            burst_left--;
            if (burst_left <= 0)
            begin
                // End of a burst. The next gap has a random length, and some
                // gaps have length zero, so some stretches run with no idle cycles.
                burst_left = $urandom_range(1, 24);
                idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        start <= next_start;
    end

    // Monitor. done is high for exactly one cycle per response. The response is
    // taken at the edge that ends that cycle and is compared with the oldest prediction.
    always @(posedge clk)
    begin : check_responses
        deq_response_t exp_rsp;
        if (rst_n && done)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("response with no request outstanding");
                error_count++;
            end
            else
            begin
                exp_rsp = pending_responses[0];
                pending_responses.delete(0);
                if (front_value !== exp_rsp.front)
                begin
                    $error("front_value: expected %0h, got %0h", exp_rsp.front, front_value);
                    error_count++;
                end
                if (back_value !== exp_rsp.back)
                begin
                    $error("back_value: expected %0h, got %0h", exp_rsp.back, back_value);
                    error_count++;
                end
                if (entry_total !== exp_rsp.total)
                begin
                    $error("entry_total: expected %0d, got %0d", exp_rsp.total, entry_total);
                    error_count++;
                end
                if (is_empty !== exp_rsp.empty)
                begin
                    $error("is_empty: expected %0b, got %0b", exp_rsp.empty, is_empty);
                    error_count++;
                end
                if (error_code !== exp_rsp.err)
                begin
                    $error("error_code: expected %0d, got %0d", exp_rsp.err, error_code);
                    error_count++;
                end
            end
        end
    end

    // Watchdog. The run stops if neither side moves for a long time.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : run_test
        int               ops_queued;
        int               seg_len;
        int               push_pct;
        int               roll;
        logic [CMD_W-1:0] code;

        // Directed requests.
        // First, pops on an empty queue, a no-op, and every unused command code.
        add_request(CMD_POP_FRONT, '1, 1'b0);
        add_request(CMD_POP_BACK, '1, 1'b0);
        add_request(CMD_NOP, '1, 1'b0);
        for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
            add_request(CMD_WIDTH'(c), $urandom, 1'b0);
        // Push into an empty queue, then pop that single entry. After this,
        // the indices stay put and the next push reuses the same slot.
        add_request(CMD_PUSH_FRONT, '1, 1'b0);
        add_request(CMD_POP_BACK, '0, 1'b0);
        add_request(CMD_PUSH_BACK, '0, 1'b0);
        add_request(CMD_PUSH_FRONT, 32'h8000_0001, 1'b0);
        add_request(CMD_PUSH_BACK, 32'h7FFF_FFFE, 1'b0);
        add_request(CMD_PUSH_FRONT, 32'h1234_5678, 1'b0);
        add_request(CMD_POP_BACK, '0, 1'b0);
        add_request(CMD_POP_FRONT, '0, 1'b0);
        add_request(CMD_POP_FRONT, '0, 1'b0);
        add_request(CMD_POP_BACK, '0, 1'b0);
        add_request(CMD_POP_FRONT, '0, 1'b0);

        // Random requests come in segments, and each segment has its own push bias.
        // Strongly push-biased segments fill the queue and then run into the
        // full case. Pop-biased segments drain it and probe the empty case. Some
        // segments wait for every response before they start. The first
        // segment always waits.
        ops_queued = 0;
        while (ops_queued < RANDOM_OPS)
        begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
                0:       push_pct = 15;
                1:       push_pct = 50;
                2:       push_pct = 85;
                default: push_pct = 97;
            endcase
            for (int i = 0; i < seg_len; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    code = ($urandom_range(0, 4) == 0) ?
                           CMD_WIDTH'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST)) :
                           CMD_NOP;
                else if ($urandom_range(0, 99) < push_pct)
                    code = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                else
                    code = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
                if (roll >= 5)
                    ops_queued++;
                add_request(code, pick_value(),
                            (i == 0) && (ops_queued <= 1 || $urandom_range(0, 3) == 0));
            end
        end

        // Hold reset for a fixed number of cycles and release it at a rising edge.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request has been taken and every response checked.
        // Then give the block a few more cycles, so any extra response shows up.
        while (request_backlog.size() != 0 || start)
            @(posedge clk);
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/deq_dpath.sv
design/double_ended_queue.sv
verif/testbench.sv
